/* design/selective_repeat_send_window_unit_assert.svh */
// Assertion helpers used by the send window controller.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_UNIT_ASSERT_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SRSW_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRSW_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/srsw_pkg.sv */
package srsw_pkg;

  // Field widths
  localparam int OFF_W      = 32;
  localparam int PLEN_W     = 11;
  localparam int SLOT_W     = 6;
  localparam int SLIDE_W    = 6;
  localparam int WIN_W      = 7;
  localparam int CODE_W     = 2;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Payload limit per packet
  localparam int MAX_PAYLOAD = 1479;
  localparam int MIN_WIN     = 2;

  // Register reset values
  localparam logic [OFF_W-1:0]   FILE_SIZE_RST = '0;
  localparam logic [SLIDE_W-1:0] SLIDE_RST     = 6'd16;
  localparam logic [WIN_W-1:0]   WIN_RST       = 7'd32;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FILE_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLIDE_LEN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEN = 2'd2;

  // Request codes
  localparam logic [CODE_W-1:0] REQ_NEW     = 2'd0;
  localparam logic [CODE_W-1:0] REQ_ACK     = 2'd1;
  localparam logic [CODE_W-1:0] REQ_TIMEOUT = 2'd2;
  localparam logic [CODE_W-1:0] REQ_FIN     = 2'd3;

  // Action codes
  localparam logic [CODE_W-1:0] ACT_SEND   = 2'd0;
  localparam logic [CODE_W-1:0] ACT_RESEND = 2'd1;
  localparam logic [CODE_W-1:0] ACT_NONE   = 2'd2;
  localparam logic [CODE_W-1:0] ACT_DONE   = 2'd3;

  // Timer commands
  localparam logic [CODE_W-1:0] TMR_LEAVE = 2'd0;
  localparam logic [CODE_W-1:0] TMR_START = 2'd1;
  localparam logic [CODE_W-1:0] TMR_STOP  = 2'd2;

  // Source of the must_wait flag
  typedef enum logic [1:0] {
    W_ZERO,
    W_ONE,
    W_COND
  } wait_sel_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_ACK,
    RD_BASE,
    RD_SCAN
  } rd_sel_t;

  // Result descriptor loaded into the output register
  typedef struct packed {
    logic [CODE_W-1:0] action;
    logic              use_pend;
    logic [CODE_W-1:0] tcmd;
    wait_sel_t         wait_sel;
    logic              resume;
    logic              last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    cap;
    logic    norm;
    logic    size_en;
    logic    claim;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ack_wr;
    logic    base_step;
    logic    timer_set;
    logic    timer_clr;
    logic    scan_load;
    logic    scan_step;
    logic    pend_load;
    logic    out_load;
    res_t    res;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              req_valid;
    logic [CODE_W-1:0] req_type;
    logic              norm_ok;
    logic              exhausted;
    logic              timer_running;
    logic              aslot_in_win;
    logic              ent_match;
    logic              ent_used;
    logic              aslot_is_base;
    logic              jump_ok;
    logic              base_at_last;
    logic              base_is_abase;
    logic              scan_at_end;
    logic              out_free;
  } ctl_sts_t;

  function automatic res_t mk_res(logic [CODE_W-1:0] action, logic use_pend,
                                  logic [CODE_W-1:0] tcmd, wait_sel_t wait_sel,
                                  logic resume, logic last);
    res_t r;
    r.action   = action;
    r.use_pend = use_pend;
    r.tcmd     = tcmd;
    r.wait_sel = wait_sel;
    r.resume   = resume;
    r.last     = last;
    return r;
  endfunction

endpackage

/* design/srsw_req_if.sv */
interface srsw_req_if;
  import srsw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   req_type;
  logic [PLEN_W-1:0]   payload_len;
  logic [SLOT_W-1:0]   ack_slot;
  logic [OFF_W-1:0]    ack_offset;
  logic [SLOT_W-1:0]   ack_window_base;

  modport source (
    output valid, req_type, payload_len, ack_slot, ack_offset, ack_window_base,
    input  ready
  );

  modport sink (
    input  valid, req_type, payload_len, ack_slot, ack_offset, ack_window_base,
    output ready
  );
endinterface

/* design/srsw_res_if.sv */
interface srsw_res_if;
  import srsw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   action;
  logic [SLOT_W-1:0]   slot_out;
  logic [OFF_W-1:0]    offset_out;
  logic [CODE_W-1:0]   timer_cmd;
  logic                must_wait;
  logic                resume_sending;
  logic                last_out;

  modport source (
    output valid, action, slot_out, offset_out, timer_cmd, must_wait,
           resume_sending, last_out,
    input  ready
  );

  modport sink (
    input  valid, action, slot_out, offset_out, timer_cmd, must_wait,
           resume_sending, last_out,
    output ready
  );
endinterface

/* design/srsw_dp.sv */
module srsw_dp #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  srsw_req_if.sink                          req,
  srsw_res_if.source                        res,
  input  srsw_pkg::ctl_cmd_t                cmd,
  output srsw_pkg::ctl_sts_t                sts
);
  import srsw_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int WW = IW + 1;
  localparam int SW = IW + 2;

  // Configuration registers
  logic [OFF_W-1:0]   file_size;
  logic [SLIDE_W-1:0] slide_reg;
  logic [WIN_W-1:0]   win_reg;

  // Latched request
  logic [CODE_W-1:0] it_type;
  logic [PLEN_W-1:0] it_plen;
  logic [SLOT_W-1:0] it_aslot;
  logic [OFF_W-1:0]  it_aoff;
  logic [SLOT_W-1:0] it_abase;

  // Window state
  logic [IW-1:0]        base;
  logic [IW-1:0]        ns;
  logic [OFF_W-1:0]     no;
  logic                 timer_q;
  logic [MAX_SLOTS-1:0] valid;
  logic [IW-1:0]        scan;

  // Slot memory: {acked, offset}
  logic [OFF_W:0]       mem [MAX_SLOTS];
  logic [OFF_W:0]       rd_q;
  logic [IW-1:0]        rd_addr_q;

  // Pending result and sizing
  logic [IW-1:0]     pend_slot;
  logic [OFF_W-1:0]  pend_off;
  logic [PLEN_W-1:0] plen_eff;

  // Output register
  logic              out_valid;
  logic [CODE_W-1:0] o_action;
  logic [SLOT_W-1:0] o_slot;
  logic [OFF_W-1:0]  o_off;
  logic [CODE_W-1:0] o_tcmd;
  logic              o_wait;
  logic              o_resume;
  logic              o_last;

  // Derived values
  logic [WW-1:0]     win;
  logic [WW-1:0]     sl;
  logic [IW-1:0]     last;
  logic [IW-1:0]     ack_idx;
  logic [IW-1:0]     abase_idx;
  logic [SW-1:0]     slide_sum;
  logic [IW-1:0]     slide_end;
  logic [WW-1:0]     jdist;
  logic              exhausted;
  logic              wait_cond;
  logic              abase_in_win;
  logic [PLEN_W-1:0] p_cap;
  logic [OFF_W-1:0]  rem;
  logic [PLEN_W-1:0] p_lim;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [OFF_W:0]    mem_wd;
  logic              wait_bit;
  logic              out_free;

  function automatic logic [IW-1:0] inc_wrap(logic [IW-1:0] v, logic [WW-1:0] w);
    logic [WW-1:0] t;
    t = WW'(v) + WW'(1);
    return (t == w) ? '0 : t[IW-1:0];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= FILE_SIZE_RST;
      slide_reg <= SLIDE_RST;
      win_reg   <= WIN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FILE_SIZE:  file_size <= cfg_wdata;
        CFG_SLIDE_LEN:  slide_reg <= cfg_wdata[SLIDE_W-1:0];
        CFG_WINDOW_LEN: win_reg   <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp window and slide
  always_comb begin
    if (win_reg < WIN_W'(MIN_WIN)) begin
      win = WW'(MIN_WIN);
    end else if (win_reg > WIN_W'(MAX_SLOTS)) begin
      win = WW'(MAX_SLOTS);
    end else begin
      win = WW'(win_reg);
    end
    if (slide_reg == '0) begin
      sl = WW'(1);
    end else if (WIN_W'(slide_reg) > WIN_W'(win)) begin
      sl = win;
    end else begin
      sl = WW'(slide_reg);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      it_type  <= req.req_type;
      it_plen  <= req.payload_len;
      it_aslot <= req.ack_slot;
      it_aoff  <= req.ack_offset;
      it_abase <= req.ack_window_base;
    end
  end

  assign ack_idx   = it_aslot[IW-1:0];
  assign abase_idx = it_abase[IW-1:0];
  assign last      = (ns == '0) ? IW'(win - WW'(1)) : ns - IW'(1);
  assign exhausted = (no >= file_size);

  // Slot that closes the current slide
  always_comb begin
    slide_sum = SW'(base) + SW'(sl) - SW'(1);
    if (slide_sum >= SW'(win)) begin
      slide_sum = slide_sum - SW'(win);
    end
    slide_end = slide_sum[IW-1:0];
  end
  assign wait_cond = exhausted || (last == slide_end);

  // Distance from base to the receiver's base
  always_comb begin
    if (abase_idx >= base) begin
      jdist = WW'(abase_idx) - WW'(base);
    end else begin
      jdist = WW'(abase_idx) + win - WW'(base);
    end
  end
  assign abase_in_win = (WIN_W'(it_abase) < WIN_W'(win));

  // Payload sizing
  always_comb begin
    rem   = file_size - no;
    p_cap = (OFF_W'(it_plen) > OFF_W'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD) : it_plen;
    p_lim = (OFF_W'(p_cap) > rem) ? PLEN_W'(rem) : p_cap;
  end

  always_ff @(posedge clk) begin
    if (cmd.size_en) begin
      plen_eff <= p_lim;
    end
  end

  // Base, next slot, running offset and timer
  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= '0;
      ns      <= '0;
      no      <= '0;
      timer_q <= 1'b0;
    end else begin
      if (cmd.norm) begin
        if (WW'(base) >= win) base <= IW'(WW'(base) - win);
        if (WW'(ns) >= win)   ns   <= IW'(WW'(ns) - win);
      end
      if (cmd.base_step) begin
        base <= inc_wrap(base, win);
      end
      if (cmd.claim) begin
        ns <= inc_wrap(ns, win);
        no <= no + OFF_W'(plen_eff);
      end
      if (cmd.timer_clr) begin
        timer_q <= 1'b0;
      end else if (cmd.timer_set) begin
        timer_q <= 1'b1;
      end
    end
  end

  // Occupied flags; a clear flag reads as an empty slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (cmd.claim)     valid[ns]   <= 1'b1;
      if (cmd.base_step) valid[base] <= 1'b0;
    end
  end

  // Memory ports
  always_comb begin
    case (cmd.rd_sel)
      RD_ACK:  rd_addr = ack_idx;
      RD_BASE: rd_addr = base;
      RD_SCAN: rd_addr = scan;
      default: rd_addr = base;
    endcase
  end

  assign mem_we = cmd.claim || cmd.ack_wr;
  assign mem_wa = cmd.claim ? ns : ack_idx;
  assign mem_wd = cmd.claim ? {1'b0, no} : {1'b1, rd_q[OFF_W-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Resend scan pointer and pending result
  always_ff @(posedge clk) begin
    if (cmd.scan_load) begin
      scan <= base;
    end else if (cmd.scan_step) begin
      scan <= inc_wrap(scan, win);
    end
    if (cmd.claim) begin
      pend_slot <= ns;
      pend_off  <= no;
    end else if (cmd.pend_load) begin
      pend_slot <= scan;
      pend_off  <= rd_q[OFF_W-1:0];
    end
  end

  // Output register
  assign out_free = !out_valid || res.ready;

  always_comb begin
    case (cmd.res.wait_sel)
      W_ZERO:  wait_bit = 1'b0;
      W_ONE:   wait_bit = 1'b1;
      W_COND:  wait_bit = wait_cond;
      default: wait_bit = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_action <= cmd.res.action;
      o_slot   <= cmd.res.use_pend ? SLOT_W'(pend_slot) : '0;
      o_off    <= cmd.res.use_pend ? pend_off : '0;
      o_tcmd   <= cmd.res.tcmd;
      o_wait   <= wait_bit;
      o_resume <= cmd.res.resume;
      o_last   <= cmd.res.last;
    end
  end

  assign res.valid          = out_valid;
  assign res.action         = o_action;
  assign res.slot_out       = o_slot;
  assign res.offset_out     = o_off;
  assign res.timer_cmd      = o_tcmd;
  assign res.must_wait      = o_wait;
  assign res.resume_sending = o_resume;
  assign res.last_out       = o_last;

  assign req.ready = cmd.in_ready;

  // Status to the controller
  always_comb begin
    sts.req_valid     = req.valid;
    sts.req_type      = it_type;
    sts.norm_ok       = (WW'(base) < win) && (WW'(ns) < win);
    sts.exhausted     = exhausted;
    sts.timer_running = timer_q;
    sts.aslot_in_win  = (WIN_W'(it_aslot) < WIN_W'(win));
    sts.ent_match     = valid[rd_addr_q] && !rd_q[OFF_W] && (rd_q[OFF_W-1:0] == it_aoff);
    sts.ent_used      = valid[rd_addr_q] && rd_q[OFF_W];
    sts.aslot_is_base = (ack_idx == base);
    sts.jump_ok       = abase_in_win && (jdist != '0) && (jdist < sl);
    sts.base_at_last  = (base == last);
    sts.base_is_abase = (abase_idx == base);
    sts.scan_at_end   = (scan == ns);
    sts.out_free      = out_free;
  end

endmodule

/* design/srsw_ctrl.sv */
`include "selective_repeat_send_window_unit_assert.svh"

module srsw_ctrl (
  input  logic               clk,
  input  logic               rst,
  output srsw_pkg::ctl_cmd_t cmd,
  input  srsw_pkg::ctl_sts_t sts
);
  import srsw_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_NORM      = 12'b0000_0000_0010,
    S_NEW_SIZE  = 12'b0000_0000_0100,
    S_NEW_CLAIM = 12'b0000_0000_1000,
    S_ACK_RD    = 12'b0000_0001_0000,
    S_ACK_CHK   = 12'b0000_0010_0000,
    S_SLIDE_RD  = 12'b0000_0100_0000,
    S_SLIDE_CHK = 12'b0000_1000_0000,
    S_JUMP      = 12'b0001_0000_0000,
    S_TO_RD     = 12'b0010_0000_0000,
    S_TO_CHK    = 12'b0100_0000_0000,
    S_EMIT      = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  res_t   res_q, res_next;
  logic   pend_have, pend_have_next;
  logic   pend_first, pend_first_next;
  logic   first, first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_have  <= 1'b0;
      pend_first <= 1'b0;
      first      <= 1'b0;
    end else begin
      state      <= state_next;
      pend_have  <= pend_have_next;
      pend_first <= pend_first_next;
      first      <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
  end

  // Sequencer
  always_comb begin
    cmd             = '0;
    cmd.rd_sel      = RD_BASE;
    cmd.res         = res_q;
    state_next      = state;
    res_next        = res_q;
    pend_have_next  = pend_have;
    pend_first_next = pend_first;
    first_next      = first;

    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.req_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_NORM;
        end
      end

      // bring base and next slot back inside the window, then dispatch
      S_NORM: begin
        if (!sts.norm_ok) begin
          cmd.norm = 1'b1;
        end else begin
          case (sts.req_type)
            REQ_NEW: begin
              if (sts.exhausted) begin
                res_next   = mk_res(ACT_NONE, 1'b0, TMR_LEAVE, W_ONE, 1'b0, 1'b1);
                state_next = S_EMIT;
              end else begin
                state_next = S_NEW_SIZE;
              end
            end
            REQ_ACK: begin
              state_next = S_ACK_RD;
            end
            REQ_TIMEOUT: begin
              cmd.timer_set  = 1'b1;
              cmd.scan_load  = 1'b1;
              first_next     = 1'b1;
              pend_have_next = 1'b0;
              state_next     = S_TO_RD;
            end
            default: begin
              res_next = mk_res(ACT_DONE, 1'b0,
                                sts.timer_running ? TMR_STOP : TMR_LEAVE,
                                W_ZERO, 1'b0, 1'b1);
              cmd.timer_clr = 1'b1;
              state_next    = S_EMIT;
            end
          endcase
        end
      end

      S_NEW_SIZE: begin
        cmd.size_en = 1'b1;
        state_next  = S_NEW_CLAIM;
      end

      S_NEW_CLAIM: begin
        cmd.claim     = 1'b1;
        cmd.timer_set = 1'b1;
        res_next      = mk_res(ACT_SEND, 1'b1,
                               sts.timer_running ? TMR_LEAVE : TMR_START,
                               W_COND, 1'b0, 1'b1);
        state_next    = S_EMIT;
      end

      S_ACK_RD: begin
        if (!sts.aslot_in_win) begin
          res_next   = mk_res(ACT_NONE, 1'b0, TMR_LEAVE, W_ONE, 1'b0, 1'b1);
          state_next = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ACK;
          state_next = S_ACK_CHK;
        end
      end

      // mark acked, then slide from the base or jump toward the receiver base
      S_ACK_CHK: begin
        if (!sts.ent_match) begin
          res_next   = mk_res(ACT_NONE, 1'b0, TMR_LEAVE, W_ONE, 1'b0, 1'b1);
          state_next = S_EMIT;
        end else begin
          cmd.ack_wr    = 1'b1;
          cmd.timer_set = 1'b1;
          if (sts.aslot_is_base) begin
            res_next   = mk_res(ACT_NONE, 1'b0, TMR_START, W_COND, 1'b1, 1'b1);
            state_next = S_SLIDE_RD;
          end else begin
            res_next   = mk_res(ACT_NONE, 1'b0, TMR_START, W_ONE, 1'b0, 1'b1);
            state_next = sts.jump_ok ? S_JUMP : S_EMIT;
          end
        end
      end

      S_SLIDE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BASE;
        state_next = S_SLIDE_CHK;
      end

      S_SLIDE_CHK: begin
        if (sts.ent_used) begin
          cmd.base_step = 1'b1;
          if (sts.base_at_last) begin
            cmd.timer_clr = 1'b1;
            res_next.tcmd = TMR_STOP;
            state_next    = S_EMIT;
          end else begin
            state_next = S_SLIDE_RD;
          end
        end else begin
          state_next = S_EMIT;
        end
      end

      S_JUMP: begin
        if (sts.base_is_abase) begin
          state_next = S_EMIT;
        end else begin
          cmd.base_step = 1'b1;
          if (sts.base_at_last) begin
            cmd.timer_clr = 1'b1;
            res_next.tcmd = TMR_STOP;
            state_next    = S_EMIT;
          end
        end
      end

      // resend scan: one result is held back so the final one can carry last
      S_TO_RD: begin
        if (sts.scan_at_end) begin
          if (pend_have) begin
            res_next = mk_res(ACT_RESEND, 1'b1, pend_first ? TMR_START : TMR_LEAVE,
                              W_ONE, 1'b0, 1'b1);
          end else begin
            res_next = mk_res(ACT_NONE, 1'b0, TMR_START, W_ONE, 1'b0, 1'b1);
          end
          state_next = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SCAN;
          state_next = S_TO_CHK;
        end
      end

      S_TO_CHK: begin
        if (sts.ent_used) begin
          cmd.scan_step = 1'b1;
          state_next    = S_TO_RD;
        end else if (!pend_have) begin
          cmd.pend_load   = 1'b1;
          cmd.scan_step   = 1'b1;
          pend_have_next  = 1'b1;
          pend_first_next = first;
          first_next      = 1'b0;
          state_next      = S_TO_RD;
        end else if (sts.out_free) begin
          cmd.out_load    = 1'b1;
          cmd.res         = mk_res(ACT_RESEND, 1'b1,
                                   pend_first ? TMR_START : TMR_LEAVE,
                                   W_ONE, 1'b0, 1'b0);
          cmd.pend_load   = 1'b1;
          cmd.scan_step   = 1'b1;
          pend_first_next = first;
          first_next      = 1'b0;
          state_next      = S_TO_RD;
        end
      end

      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks
  `SRSW_ASSERT_IMP(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a held result")
  `SRSW_ASSERT_IMP(a_walk_in_window, state == S_SLIDE_RD || state == S_JUMP || state == S_TO_RD, sts.norm_ok, "window walk outside the window")
  `SRSW_ASSERT_NXT(a_one_item, cmd.cap, !cmd.in_ready, "second request taken while one is in progress")

endmodule

/* design/selective_repeat_send_window_unit.sv */
// Channel | Role | Handshake       | Payload
// req     | in   | valid/ready     | req_type, payload_len, ack_slot, ack_offset, ack_window_base
// res     | out  | valid/ready     | action, slot_out, offset_out, timer_cmd, must_wait,
//         |      |                 | resume_sending, last_out
// cfg     | in   | cfg_we, no wait | cfg_addr selects the register, cfg_wdata
//
// One request at a time; every request first passes S_NORM, then its own steps, then S_EMIT.
// New packet: sizing, then claim; with the file fully queued it goes straight to S_EMIT.
// Finish: straight to S_EMIT. Ack: a window check, then a read and a check of the slot; a slide
// reads and checks each slot slid, and a jump steps the base slot by slot toward the receiver base.
// Timer expiry: a read and a check per slot from base to next slot; a result held by the sink
// stalls the item, a window change adds fold steps; sync reset clears window state and flags.
module selective_repeat_send_window_unit #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [srsw_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [srsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  srsw_req_if.sink                        req,
  srsw_res_if.source                      res
);
  import srsw_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  srsw_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  srsw_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .res       (res),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
